// ===== hdl/dqs_pkg.sv =====
package dqs_pkg;

   // Request function codes
   localparam logic [2:0] FUNC_PUSH_HEAD = 3'd0;
   localparam logic [2:0] FUNC_PUSH_TAIL = 3'd1;
   localparam logic [2:0] FUNC_POP_HEAD  = 3'd2;
   localparam logic [2:0] FUNC_POP_TAIL  = 3'd3;
   localparam logic [2:0] FUNC_SEARCH    = 3'd4;

   // Result status codes
   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== hdl/dqs_store.sv =====
module dqs_store #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AddrWidth-1:0]  wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [AddrWidth-1:0]  rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/double_ended_queue_with_search_top.sv =====
// Channel   Direction  Handshake         Payload
// req       in         req_valid/stall   req_func, req_data_value
// rsp       out        rsp_valid/stall   rsp_status, rsp_popped_value,
//                                        rsp_found_position, rsp_entry_count
//
// Push, no-op and any full or empty case: the request passes S_EXEC, then S_OUT.
// Pop adds S_POP between them; the slot store has a registered read port.
// Search over n entries: one compare per cycle behind the slot read, in S_SEARCH,
// ending at the first match from the head or once all n entries have been compared.
// Synchronous active-high reset empties the queue; slot contents are not cleared.
// A stalled result waits in the output register while the next request is taken.
module double_ended_queue_with_search_top
   import dqs_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_data_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_popped_value,
   output logic [3:0]         rsp_found_position,
   output logic [4:0]         rsp_entry_count
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP,
      S_SEARCH,
      S_OUT
   } state_type;

   state_type             state_ff;
   logic [2:0]            func_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [IW-1:0]         head_ff;
   logic [CW-1:0]         count_ff;
   logic [IW-1:0]         ptr_ff;
   logic [CW-1:0]         idx_ff;
   logic                  cmp_valid_ff;
   logic [IW-1:0]         cmp_pos_ff;
   logic [1:0]            res_status_ff;
   logic [DATA_WIDTH-1:0] res_popped_ff;
   logic [IW-1:0]         res_pos_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic [31:0]           rsp_popped_ff;
   logic [3:0]            rsp_pos_ff;
   logic [4:0]            rsp_count_ff;

   logic                  is_full;
   logic                  is_empty;
   logic [SW-1:0]         tail_sum;
   logic [SW-1:0]         last_sum;
   logic [IW-1:0]         tail_next;
   logic [IW-1:0]         tail_last;
   logic [IW-1:0]         head_dec;
   logic [IW-1:0]         head_inc;
   logic [IW-1:0]         ptr_inc;
   logic                  issue_ok;
   logic                  hit;
   logic                  wr_en;
   logic [IW-1:0]         wr_addr;
   logic [IW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  out_free;

   // Occupancy and circular index arithmetic
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign last_sum  = tail_sum - SW'(1);
   assign tail_next = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
   assign tail_last = (last_sum >= SW'(DEPTH)) ? IW'(last_sum - SW'(DEPTH)) : IW'(last_sum);
   assign head_dec  = (head_ff == '0) ? IW'(DEPTH - 1) : head_ff - IW'(1);
   assign head_inc  = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + IW'(1);
   assign ptr_inc   = (ptr_ff == IW'(DEPTH - 1)) ? '0 : ptr_ff + IW'(1);

   // Search walk: issue the next slot read, compare the previous one
   assign issue_ok = (idx_ff < count_ff);
   assign hit      = cmp_valid_ff && (rd_data == value_ff);

   // Store port control
   assign wr_en   = (state_ff == S_EXEC) && !is_full &&
                    ((func_ff == FUNC_PUSH_HEAD) || (func_ff == FUNC_PUSH_TAIL));
   assign wr_addr = (func_ff == FUNC_PUSH_HEAD) ? head_dec : tail_next;
   assign rd_addr = (state_ff == S_SEARCH)       ? ptr_ff  :
                    (func_ff == FUNC_POP_HEAD)   ? head_ff : tail_last;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   dqs_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer, queue state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register: set on load, cleared once transferred
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff  <= req_func;
                  value_ff <= DATA_WIDTH'($unsigned(req_data_value));
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               res_popped_ff <= '0;
               res_pos_ff    <= '0;
               case (func_ff)
                  FUNC_PUSH_HEAD: begin
                     res_status_ff <= is_full ? ST_FULL : ST_DONE;
                     state_ff      <= S_OUT;
                     if (!is_full) begin
                        head_ff  <= head_dec;
                        count_ff <= count_ff + CW'(1);
                     end
                  end
                  FUNC_PUSH_TAIL: begin
                     res_status_ff <= is_full ? ST_FULL : ST_DONE;
                     state_ff      <= S_OUT;
                     if (!is_full) begin
                        count_ff <= count_ff + CW'(1);
                     end
                  end
                  FUNC_POP_HEAD, FUNC_POP_TAIL: begin
                     res_status_ff <= is_empty ? ST_EMPTY : ST_DONE;
                     state_ff      <= is_empty ? S_OUT : S_POP;
                  end
                  FUNC_SEARCH: begin
                     ptr_ff       <= head_ff;
                     idx_ff       <= '0;
                     cmp_valid_ff <= 1'b0;
                     state_ff     <= S_SEARCH;
                  end
                  default: begin
                     res_status_ff <= ST_DONE;
                     state_ff      <= S_OUT;
                  end
               endcase
            end
            S_POP: begin
               res_popped_ff <= rd_data;
               count_ff      <= count_ff - CW'(1);
               if (func_ff == FUNC_POP_HEAD) begin
                  head_ff <= head_inc;
               end
               state_ff <= S_OUT;
            end
            S_SEARCH: begin
               if (hit) begin
                  res_status_ff <= ST_DONE;
                  res_pos_ff    <= cmp_pos_ff;
                  state_ff      <= S_OUT;
               end else if (!issue_ok && !cmp_valid_ff) begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= S_OUT;
               end else begin
                  cmp_valid_ff <= issue_ok;
                  cmp_pos_ff   <= IW'(idx_ff);
                  idx_ff       <= idx_ff + CW'(1);
                  ptr_ff       <= ptr_inc;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_popped_ff <= 32'(res_popped_ff);
                  rsp_pos_ff    <= 4'(res_pos_ff);
                  rsp_count_ff  <= 5'(count_ff);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_popped_value   = rsp_popped_ff;
   assign rsp_found_position = rsp_pos_ff;
   assign rsp_entry_count    = rsp_count_ff;

endmodule
